>>> design/rpme_pkg.sv
// rpme_pkg: shared types and constants for the refresh period median estimator
// no dependencies

package rpme_pkg;

    // history ring; depth must be a power of two so ring indexes wrap naturally
    localparam int HIST_AW     = 4;
    localparam int HIST_DEPTH  = 1 << HIST_AW;
    localparam int MEDIAN_N    = 15;
    localparam int CNT_W       = $clog2(HIST_DEPTH + 1);

    localparam int PERIOD_W    = 40;
    localparam int TIME_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int FREQ_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int QUO_W       = TIME_W + FRAC_BITS;
    localparam int SCALED_W    = PERIOD_W + 10;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_SCALE,
        ST_WINDOW,
        ST_PUBCHK,
        ST_MED_RDC,
        ST_MED_LDC,
        ST_MED_SCAN,
        ST_MED_EVAL,
        ST_FINISH
    } state_t;

    // request to the serial divider
    typedef struct packed {
        logic                 start;
        logic [TIME_W-1:0]    dividend;
        logic [COUNT_W-1:0]   divisor;
    } div_req_t;

    // answer from the serial divider
    typedef struct packed {
        logic                 done;
        logic [PERIOD_W-1:0]  period;
    } div_rsp_t;

endpackage

>>> design/refresh_period_median_estimator_core.sv
// refresh_period_median_estimator_core: top level, sequencer and published estimate
// depends on rpme_pkg, rpme_div, rpme_ram
//
// Usage:
// - input channel (in_valid/in_ready) takes one word: cmd, stats_ok, sync_time,
//   sync_count. Every accepted word yields exactly one output word.
// - output channel (out_valid/out_ready) carries estimate_valid, period_estimate
//   (32.8 ticks) and last_vblank_time, the currently published estimate.
// - cfg channel (cfg_valid/cfg_ready) writes counter_frequency; always ready,
//   write it only while the block is idle.
// - one word at a time: in_ready is high only in the idle state.
// - timing: a clear or ignored word goes straight to the finish step; a sample
//   forming a period waits on the 72-step serial divider; a median publication
//   is bounded by the single read port of the history ram, scanned once per
//   candidate.
// - the result sits in an output register; the next word is accepted while it
//   waits, and that word's result is held until out_ready takes the first.
// - reset: frequency 10000000, no previous sample, empty history, no estimate.

module refresh_period_median_estimator_core
    import rpme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic                stats_ok,
    input  logic [TIME_W-1:0]   sync_time,
    input  logic [COUNT_W-1:0]  sync_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                estimate_valid,
    output logic [PERIOD_W-1:0] period_estimate,
    output logic [TIME_W-1:0]   last_vblank_time,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FREQ_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [FREQ_W-1:0]   freq_reg;
    logic [TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic [COUNT_W-1:0]  prev_count_reg, prev_count_next;
    logic                have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]    hist_count_reg, hist_count_next;
    logic [HIST_AW-1:0]  base_reg, base_next;
    logic                pub_valid_reg, pub_valid_next;
    logic [PERIOD_W-1:0] pub_period_reg, pub_period_next;
    logic [TIME_W-1:0]   pub_time_reg, pub_time_next;
    logic                out_valid_reg, out_valid_next;
    logic                est_valid_reg, est_valid_next;
    logic [PERIOD_W-1:0] est_period_reg, est_period_next;
    logic [TIME_W-1:0]   est_time_reg, est_time_next;
    logic [HIST_AW-1:0]  cand_reg, cand_next;
    logic [HIST_AW-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]    lt_reg, lt_next;
    logic [CNT_W-1:0]    le_reg, le_next;

    // payload latches, no reset
    logic                cmd_reg, stats_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] cand_val_reg, cand_val_next;
    logic [SCALED_W-1:0] scaled_reg, lo_reg, hi_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr, ram_raddr;
    logic [PERIOD_W-1:0] ram_rdata;

    logic                in_acc;
    logic [CNT_W-1:0]    half_n;
    logic                out_free;

    assign in_acc    = in_valid && in_ready;
    assign half_n    = hist_count_reg >> 1;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    rpme_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rpme_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (period_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        prev_time_next  = prev_time_reg;
        prev_count_next = prev_count_reg;
        have_prev_next  = have_prev_reg;
        hist_count_next = hist_count_reg;
        base_next       = base_reg;
        pub_valid_next  = pub_valid_reg;
        pub_period_next = pub_period_reg;
        pub_time_next   = pub_time_reg;
        out_valid_next  = out_valid_reg;
        est_valid_next  = est_valid_reg;
        est_period_next = est_period_reg;
        est_time_next   = est_time_reg;
        cand_next       = cand_reg;
        scan_next       = scan_reg;
        lt_next         = lt_reg;
        le_next         = le_reg;
        period_next     = period_reg;
        cand_val_next   = cand_val_reg;
        in_ready        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = time_reg - prev_time_reg;
        div_req.divisor  = count_reg - prev_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = base_reg + hist_count_reg[HIST_AW-1:0];
        ram_raddr       = base_reg + cand_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    prev_time_next  = '0;
                    prev_count_next = '0;
                    have_prev_next  = 1'b0;
                    hist_count_next = '0;
                    base_next       = '0;
                    pub_valid_next  = 1'b0;
                    pub_period_next = '0;
                    pub_time_next   = '0;
                    state_next      = ST_FINISH;
                end
                else if (!stats_reg || time_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_PUBCHK;
                    if (have_prev_reg)
                    begin
                        if (count_reg < prev_count_reg)
                        begin
                            hist_count_next = '0;
                        end
                        else if (count_reg > prev_count_reg)
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    prev_time_next  = time_reg;
                    prev_count_next = count_reg;
                    have_prev_next  = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    period_next = div_rsp.period;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_WINDOW;
            end
            ST_WINDOW:
            begin
                if (scaled_reg >= lo_reg && scaled_reg <= hi_reg)
                begin
                    if (hist_count_reg < CNT_W'(HIST_DEPTH))
                    begin
                        ram_we          = 1'b1;
                        hist_count_next = hist_count_reg + 1'b1;
                    end
                end
                else
                begin
                    hist_count_next = '0;
                end
                state_next = ST_PUBCHK;
            end
            ST_PUBCHK:
            begin
                cand_next = '0;
                if (hist_count_reg >= CNT_W'(MEDIAN_N))
                begin
                    state_next = ST_MED_RDC;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MED_RDC:
            begin
                ram_raddr  = base_reg + cand_reg;
                state_next = ST_MED_LDC;
            end
            ST_MED_LDC:
            begin
                cand_val_next = ram_rdata;
                ram_raddr     = base_reg;
                scan_next     = '0;
                lt_next       = '0;
                le_next       = '0;
                state_next    = ST_MED_SCAN;
            end
            ST_MED_SCAN:
            begin
                // count history entries below and not above the candidate
                if (ram_rdata < cand_val_reg)
                begin
                    lt_next = lt_reg + 1'b1;
                end
                if (ram_rdata <= cand_val_reg)
                begin
                    le_next = le_reg + 1'b1;
                end
                ram_raddr = base_reg + scan_reg + 1'b1;
                scan_next = scan_reg + 1'b1;
                if ({1'b0, scan_reg} == hist_count_reg - 1'b1)
                begin
                    state_next = ST_MED_EVAL;
                end
            end
            ST_MED_EVAL:
            begin
                // candidate sits at sorted position n/2
                if (lt_reg <= half_n && le_reg > half_n)
                begin
                    pub_valid_next  = 1'b1;
                    pub_period_next = cand_val_reg;
                    pub_time_next   = time_reg;
                    base_next       = base_reg
                                    + HIST_AW'(hist_count_reg - half_n);
                    hist_count_next = half_n;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = ST_MED_RDC;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    est_valid_next  = pub_valid_reg;
                    est_period_next = pub_period_reg;
                    est_time_next   = pub_time_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and published state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            freq_reg       <= FREQ_RESET;
            prev_time_reg  <= '0;
            prev_count_reg <= '0;
            have_prev_reg  <= 1'b0;
            hist_count_reg <= '0;
            base_reg       <= '0;
            pub_valid_reg  <= 1'b0;
            pub_period_reg <= '0;
            pub_time_reg   <= '0;
            out_valid_reg  <= 1'b0;
            est_valid_reg  <= 1'b0;
            est_period_reg <= '0;
            est_time_reg   <= '0;
            cand_reg       <= '0;
            scan_reg       <= '0;
            lt_reg         <= '0;
            le_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                freq_reg <= cfg_data;
            end
            prev_time_reg  <= prev_time_next;
            prev_count_reg <= prev_count_next;
            have_prev_reg  <= have_prev_next;
            hist_count_reg <= hist_count_next;
            base_reg       <= base_next;
            pub_valid_reg  <= pub_valid_next;
            pub_period_reg <= pub_period_next;
            pub_time_reg   <= pub_time_next;
            out_valid_reg  <= out_valid_next;
            est_valid_reg  <= est_valid_next;
            est_period_reg <= est_period_next;
            est_time_reg   <= est_time_next;
            cand_reg       <= cand_next;
            scan_reg       <= scan_next;
            lt_reg         <= lt_next;
            le_reg         <= le_next;
        end
    end

    // input word capture and window arithmetic
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg   <= cmd;
            stats_reg <= stats_ok;
            time_reg  <= sync_time;
            count_reg <= sync_count;
        end
        period_reg   <= period_next;
        cand_val_reg <= cand_val_next;
        scaled_reg   <= SCALED_W'(period_reg) * SCALED_W'(1000);
        lo_reg       <= SCALED_W'(freq_reg) << 8;
        hi_reg       <= SCALED_W'(freq_reg) * SCALED_W'(25600);
    end

    assign out_valid        = out_valid_reg;
    assign estimate_valid   = est_valid_reg;
    assign period_estimate  = est_period_reg;
    assign last_vblank_time = est_time_reg;

    // history never holds more entries than the ram
    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hist_count_reg <= CNT_W'(HIST_DEPTH))
        else $error("history count beyond depth");

    // a new output word comes only out of the finish step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output word without finish");

    // a clear leaves no published estimate
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && cmd_reg == CMD_CLEAR) |=>
            (!pub_valid_reg && hist_count_reg == '0))
        else $error("clear left state behind");

    // no history write outside the window step
    a_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WINDOW))
        else $error("history written outside window step");

endmodule

>>> design/rpme_ram.sv
// rpme_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rpme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/rpme_div.sv
// rpme_div: bit-serial restoring divider, floor(dividend * 256 / divisor)
// depends on rpme_pkg; result saturates to the 40-bit maximum

module rpme_div
    import rpme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int ITER_W = $clog2(QUO_W + 1);

    logic [QUO_W-1:0]   dvd_reg, dvd_next;
    logic [COUNT_W:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] dsr_reg, dsr_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic               qbit;

    // one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg[COUNT_W-1:0], dvd_reg[QUO_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        iter_next = iter_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = {req.dividend, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dsr_next  = req.divisor;
            iter_next = ITER_W'(QUO_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = qbit ? (trial - {1'b0, dsr_reg}) : trial;
            dvd_next  = {dvd_reg[QUO_W-2:0], qbit};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // saturate when the quotient does not fit in 32.8
    assign rsp.done   = done_reg;
    assign rsp.period = (dvd_reg[QUO_W-1:PERIOD_W] != '0) ? {PERIOD_W{1'b1}}
                                                          : dvd_reg[PERIOD_W-1:0];

endmodule
